@@ rtl/core/hfpc_pkg.sv @@
// ----------------------------------------------------------------------------
// hfpc_pkg: heater feedback pulse control shared definitions
// Payload and state types, constants and the level limit lookup.
// ----------------------------------------------------------------------------
package hfpc_pkg;

  localparam int unsigned SAMPLE_INTERVAL = 30;
  localparam int unsigned CNT_W   = 5;
  localparam int unsigned PULSE_W = 13;
  localparam int unsigned ADC_W   = 10;

  localparam logic [PULSE_W-1:0] PULSE_MIN = 13'd500;
  localparam logic [PULSE_W-1:0] PULSE_MAX = 13'd4500;
  localparam logic [CNT_W-1:0]   SAMPLE_LAST = CNT_W'(SAMPLE_INTERVAL);

  // floor(p*13/10) and floor(p*7/10) as one constant multiply, 2^-19 scaling
  localparam int unsigned DIV10_SHIFT = 19;
  localparam logic [19:0] MUL13_DIV10 = 20'd681577;
  localparam logic [18:0] MUL7_DIV10  = 19'd367003;

  // floor(d*624/5000), reciprocal rounded up, 2^-24 scaling
  localparam int unsigned BURST_SHIFT = 24;
  localparam logic [20:0] BURST_MUL   = 21'd2093797;

  // floor(pct*32/100), 2^-10 scaling, exact for pct up to 100
  localparam int unsigned CARRIER_SHIFT = 10;
  localparam logic [8:0]  CARRIER_MUL   = 9'd328;
  localparam logic [6:0]  PCT_MAX       = 7'd100;

  typedef enum logic {
    REQ_UPDATE   = 1'b0,
    REQ_FEEDBACK = 1'b1
  } req_type_t;

  typedef struct packed {
    logic             req_type;
    logic             running;
    logic             setup_mode;
    logic [2:0]       heat_level;
    logic             high_power;
    logic [6:0]       carrier_percent;
    logic [ADC_W-1:0] adc_sample;
  } item_t;

  typedef struct packed {
    logic               heater_enable;
    logic [5:0]         carrier_duty;
    logic [9:0]         burst_duty;
    logic [PULSE_W-1:0] pulse_duration_us;
  } result_t;

  typedef struct packed {
    logic               was_running;
    logic [PULSE_W-1:0] pulse_time;
    logic [ADC_W-1:0]   reference_reading;
    logic [ADC_W-1:0]   sensor_reading;
    logic [CNT_W-1:0]   sample_counter;
  } state_t;

  // Per-level pulse limit in us; levels outside 1..6 give zero.
  function automatic logic [PULSE_W-1:0] level_limit(input logic [2:0] level,
                                                      input logic       hi);
    logic [PULSE_W-1:0] lim;
    case (level)
      3'd1:    lim = hi ? 13'd750  : 13'd500;
      3'd2:    lim = hi ? 13'd1500 : 13'd1000;
      3'd3:    lim = hi ? 13'd2250 : 13'd1500;
      3'd4:    lim = hi ? 13'd3000 : 13'd2000;
      3'd5:    lim = hi ? 13'd3750 : 13'd2500;
      3'd6:    lim = hi ? 13'd4500 : 13'd3000;
      default: lim = '0;
    endcase
    return lim;
  endfunction

endpackage

@@ rtl/core/heater_feedback_pulse_control_unit.sv @@
// ----------------------------------------------------------------------------
// heater_feedback_pulse_control_unit: heater pulse feedback and PWM duty
// Registered input stage, combinational step logic, registered result.
// ----------------------------------------------------------------------------
// One transfer in gives one transfer out. An item is registered, worked by
// the combinational step logic against the controller state, and its result
// is written to the output register when the stage moves on. A new item is
// taken every cycle while the result register is not held; throughput is one
// item per cycle, set by the state update (pulse time, reference, sensor
// sample and counter all written together). When the result register is held
// by result_stall, the input stage fills and item_stall rises one item later.
// Feedback ticks scale the pulse time by 13/10 or 7/10 from the sensor trend,
// clamped to the level limit and 500 us; every tick tracks run edges, samples
// the sensor every 30th active tick and reports carrier and burst duty counts.
module heater_feedback_pulse_control_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  hfpc_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output hfpc_pkg::result_t result
);
  import hfpc_pkg::*;

  // input stage
  logic    stage_valid;
  item_t   stage_item;

  // controller state
  state_t  state;
  state_t  state_next;
  result_t step_result;

  logic    advance;

  // the stage moves on whenever the result register is empty or being taken
  assign advance    = !result_valid || !result_stall;
  assign item_stall = stage_valid && !advance;

  hfpc_step u_step (
    .item   (stage_item),
    .cur    (state),
    .nxt    (state_next),
    .result (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (!item_stall) begin
      stage_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!item_stall && item_valid) begin
      stage_item <= item;
    end
  end

  // state and result update only when the staged item actually advances
  always_ff @(posedge clk) begin
    if (rst) begin
      state.was_running       <= 1'b0;
      state.pulse_time        <= PULSE_MIN;
      state.reference_reading <= '0;
      state.sensor_reading    <= '0;
      state.sample_counter    <= '0;
      result_valid            <= 1'b0;
    end else if (advance) begin
      result_valid <= stage_valid;
      if (stage_valid) begin
        state <= state_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && stage_valid) begin
      result <= step_result;
    end
  end

  // counter wraps before reaching the sampling interval
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    state.sample_counter < SAMPLE_LAST)
    else $error("sample counter out of range");

  // stored pulse time stays inside its clamp window
  a_pulse_range: assert property (@(posedge clk) disable iff (rst)
    state.pulse_time >= PULSE_MIN && state.pulse_time <= PULSE_MAX)
    else $error("pulse time out of range");

  // drive off means zero duty counts
  a_off_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.heater_enable |->
      result.carrier_duty == '0 && result.burst_duty == '0)
    else $error("duty nonzero while heater off");

  // a stalled input implies a full stage behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> stage_valid && result_valid && result_stall)
    else $error("input stall without a full pipeline");

endmodule

@@ rtl/core/hfpc_step.sv @@
// ----------------------------------------------------------------------------
// hfpc_step: one tick of the pulse controller
// Combinational next state and result for one item against the current state.
// ----------------------------------------------------------------------------
module hfpc_step (
  input  hfpc_pkg::item_t   item,
  input  hfpc_pkg::state_t  cur,
  output hfpc_pkg::state_t  nxt,
  output hfpc_pkg::result_t result
);
  import hfpc_pkg::*;

  logic [PULSE_W-1:0] limit;
  logic [13:0]        cur10;
  logic [13:0]        ref11;
  logic [13:0]        ref9;
  logic [32:0]        up_prod;
  logic [31:0]        dn_prod;
  logic [PULSE_W-1:0] up_val;
  logic [PULSE_W-1:0] dn_val;
  logic [PULSE_W-1:0] fb_pulse;
  logic [ADC_W-1:0]   fb_ref;
  logic [PULSE_W-1:0] dur;
  logic [33:0]        burst_prod;
  logic [6:0]         pct;
  logic [15:0]        carrier_prod;
  logic               active;

  assign limit = level_limit(item.heat_level, item.high_power);

  // floor(x/10) <= c  <=>  x <= 10c + 9
  assign cur10 = 14'(cur.sensor_reading) * 14'd10 + 14'd9;
  assign ref11 = 14'(cur.reference_reading) * 14'd11;
  assign ref9  = 14'(cur.reference_reading) * 14'd9;

  assign up_prod = 33'(cur.pulse_time) * 33'(MUL13_DIV10);
  assign dn_prod = 32'(cur.pulse_time) * 32'(MUL7_DIV10);
  assign up_val  = up_prod[DIV10_SHIFT +: PULSE_W];
  assign dn_val  = dn_prod[DIV10_SHIFT +: PULSE_W];

  always_comb begin
    fb_pulse = cur.pulse_time;
    fb_ref   = cur.reference_reading;
    if (item.req_type == REQ_FEEDBACK) begin
      if (limit > PULSE_MIN) begin
        if (cur10 >= ref11) begin
          fb_pulse = (up_val > limit) ? limit : up_val;
        end else if (cur10 < ref9) begin
          fb_pulse = (dn_val < PULSE_MIN) ? PULSE_MIN : dn_val;
        end
        fb_ref = cur.sensor_reading;
      end else begin
        fb_pulse = PULSE_MIN;
      end
    end
  end

  assign active = item.running && !item.setup_mode;

  always_comb begin
    nxt = cur;
    nxt.pulse_time        = fb_pulse;
    nxt.reference_reading = fb_ref;
    if (item.running && !cur.was_running) begin
      nxt.pulse_time        = PULSE_MIN;
      nxt.reference_reading = item.adc_sample;
    end
    if (!item.running && cur.was_running) begin
      nxt.pulse_time        = PULSE_MIN;
      nxt.reference_reading = '0;
    end
    nxt.was_running = item.running;
    if (active) begin
      if (cur.sample_counter + CNT_W'(1) >= SAMPLE_LAST) begin
        nxt.sensor_reading = item.adc_sample;
        nxt.sample_counter = '0;
      end else begin
        nxt.sample_counter = cur.sample_counter + CNT_W'(1);
      end
    end
  end

  // burst duration clamped to [500, limit] using the updated pulse time
  always_comb begin
    dur = (nxt.pulse_time > limit) ? limit : nxt.pulse_time;
    if (dur < PULSE_MIN) begin
      dur = PULSE_MIN;
    end
  end

  assign pct          = (item.carrier_percent > PCT_MAX) ? PCT_MAX : item.carrier_percent;
  assign carrier_prod = 16'(pct) * 16'(CARRIER_MUL);
  assign burst_prod   = 34'(dur) * 34'(BURST_MUL);

  always_comb begin
    result.heater_enable     = active;
    result.carrier_duty      = active ? carrier_prod[CARRIER_SHIFT +: 6] : '0;
    result.burst_duty        = active ? burst_prod[BURST_SHIFT +: 10] : '0;
    result.pulse_duration_us = nxt.pulse_time;
  end

endmodule

@@ verif/tb_heater_feedback_pulse_control_unit.sv @@
// ----------------------------------------------------------------------------
// tb_heater_feedback_pulse_control_unit: self-checking bench for the heater
// pulse controller
// Drives update and feedback ticks over the valid/stall channel and predicts
// each result in step with the block. Every transfer out is compared field by
// field with the oldest prediction. The stimulus covers directed corners,
// treatment sessions with drifting sensor readings, random noise and long
// output back-pressure.
// ----------------------------------------------------------------------------
module tb_heater_feedback_pulse_control_unit;
  import hfpc_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned SETTLE_CYCLES = 8;     // longer than the block latency
  localparam int unsigned PRINT_CAP     = 100;   // keep the log short

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_stall;
  item_t   item = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;

  heater_feedback_pulse_control_unit dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Idle rates, in percent of cycles, for the sender and the receiver.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  // Long output hold-off; loaded by a test, counted down by the receiver.
  int unsigned recv_hold = 0;

  int unsigned cycle_count = 0;
  int unsigned mismatches  = 0;

  // Results predicted for accepted ticks, oldest first.
  result_t duty_expected[$];

  // Controller state as the predictor sees it.
  logic               prev_running = 1'b0;
  logic [PULSE_W-1:0] pulse_us     = PULSE_MIN;
  logic [ADC_W-1:0]   trend_ref    = '0;
  logic [ADC_W-1:0]   sensor_hold  = '0;
  logic [CNT_W-1:0]   tick_count   = '0;

  // --------------------------------------------------------------------------
  // Predictor: advance the controller state by one tick and return the
  // result the block must report for it.
  // --------------------------------------------------------------------------
  function automatic result_t heater_predict(input item_t it);
    int unsigned cap, cur, base, scaled, pct, dur;
    result_t     r;
    r = '0;
    // per-level pulse ceiling; levels outside 1..6 give a ceiling of zero
    if (it.heat_level >= 1 && it.heat_level <= 6)
      cap = it.heat_level * (it.high_power ? 750 : 500);
    else
      cap = 0;

    // Feedback runs ahead of the update part of the tick.
    if (it.req_type == REQ_FEEDBACK) begin
      if (cap > 500) begin
        cur    = 32'(sensor_hold);
        base   = 32'(trend_ref);
        scaled = 32'(pulse_us);
        if (cur >= (base * 11) / 10) begin
          // reading up 10% or more: lengthen by 13/10, up to the ceiling
          scaled = (scaled * 13) / 10;
          if (scaled > cap) scaled = cap;
        end else if (cur < (base * 9) / 10) begin
          // reading down more than 10%: shorten by 7/10, not below 500 us
          scaled = (scaled * 7) / 10;
          if (scaled < 500) scaled = 500;
        end
        pulse_us  = PULSE_W'(scaled);
        trend_ref = sensor_hold;
      end else begin
        pulse_us = PULSE_MIN;
      end
    end

    // Run edges restart the loop.
    if (it.running && !prev_running) begin
      pulse_us  = PULSE_MIN;
      trend_ref = it.adc_sample;
    end
    if (!it.running && prev_running) begin
      pulse_us  = PULSE_MIN;
      trend_ref = '0;
    end
    prev_running = it.running;

    // Active tick: drive the heater, sample the sensor every 30th tick.
    if (it.running && !it.setup_mode) begin
      pct = (it.carrier_percent > 100) ? 100 : 32'(it.carrier_percent);
      r.carrier_duty = 6'((32 * pct) / 100);
      if (tick_count < SAMPLE_INTERVAL) tick_count = tick_count + 1'b1;
      if (tick_count >= SAMPLE_INTERVAL) begin
        sensor_hold = it.adc_sample;
        tick_count  = '0;
      end
      dur = 32'(pulse_us);
      if (dur > cap) dur = cap;
      if (dur < 500) dur = 500;
      r.burst_duty    = 10'((dur * 624) / 5000);
      r.heater_enable = 1'b1;
    end

    r.pulse_duration_us = pulse_us;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (mismatches < PRINT_CAP)
      $display("ERROR at cycle %0d: %s got %0d, want %0d", cycle_count, what, got, want);
    mismatches++;
  endtask

  // --------------------------------------------------------------------------
  // Sender: optional idle cycles, then offer the tick and hold it until the
  // block takes it. Valid stays high on return so back-to-back transfers
  // need no extra edge.
  // --------------------------------------------------------------------------
  task automatic send_item(input item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item       <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall !== 1'b0);
    duty_expected.push_back(heater_predict(it));
  endtask

  // Stop offering, wait for every pending result, then let the pipe settle.
  task automatic wait_drained();
    item_valid <= 1'b0;
    while (duty_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic item_t make_item(input logic req, input logic run,
                                      input logic setup, input logic [2:0] lvl,
                                      input logic hi, input logic [6:0] pct,
                                      input logic [ADC_W-1:0] adc);
    item_t it;
    it.req_type        = req;
    it.running         = run;
    it.setup_mode      = setup;
    it.heat_level      = lvl;
    it.high_power      = hi;
    it.carrier_percent = pct;
    it.adc_sample      = adc;
    return it;
  endfunction

  // --------------------------------------------------------------------------
  // Receiver: random stall, or a forced hold-off while recv_hold runs down.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (recv_hold > 0) begin
      recv_hold--;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Result checker: every transfer out against the oldest prediction.
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && result_valid === 1'b1 && result_stall == 1'b0) begin
      if (duty_expected.size() == 0) begin
        report_mismatch("unexpected result, pending", 0, 0);
      end else begin
        want = duty_expected.pop_front();
        if (result.heater_enable !== want.heater_enable)
          report_mismatch("heater_enable", 32'(result.heater_enable),
                          32'(want.heater_enable));
        if (result.carrier_duty !== want.carrier_duty)
          report_mismatch("carrier_duty", 32'(result.carrier_duty),
                          32'(want.carrier_duty));
        if (result.burst_duty !== want.burst_duty)
          report_mismatch("burst_duty", 32'(result.burst_duty), 32'(want.burst_duty));
        if (result.pulse_duration_us !== want.pulse_duration_us)
          report_mismatch("pulse_duration_us", 32'(result.pulse_duration_us),
                          32'(want.pulse_duration_us));
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("heater_feedback_pulse_control_unit: mismatch");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Directed corners: idle ticks, feedback with a zero or minimal ceiling,
  // feedback on the run start tick, the climb to the ceiling, invalid
  // levels while active, percent saturation, setup mode, stop edge and a
  // fall floored at 500 us.
  // --------------------------------------------------------------------------
  task automatic test_directed_cases();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_item(make_item(REQ_UPDATE,   1'b0, 1'b0, 3'd0, 1'b0, 7'd0,   10'd0));
    send_item(make_item(REQ_FEEDBACK, 1'b0, 1'b0, 3'd7, 1'b1, 7'd127, 10'd1023));
    // feedback rise, then the start edge overrides it
    send_item(make_item(REQ_FEEDBACK, 1'b1, 1'b0, 3'd6, 1'b1, 7'd100, 10'd0));
    // reference and reading both zero: every feedback rises until capped
    repeat (9)
      send_item(make_item(REQ_FEEDBACK, 1'b1, 1'b0, 3'd6, 1'b1, 7'd127, 10'd1023));
    send_item(make_item(REQ_UPDATE,   1'b1, 1'b0, 3'd7, 1'b0, 7'd101, 10'd512));
    send_item(make_item(REQ_UPDATE,   1'b1, 1'b0, 3'd0, 1'b1, 7'd64,  10'd256));
    send_item(make_item(REQ_FEEDBACK, 1'b1, 1'b0, 3'd1, 1'b0, 7'd1,   10'd5));
    send_item(make_item(REQ_FEEDBACK, 1'b1, 1'b0, 3'd1, 1'b1, 7'd99,  10'd682));
    send_item(make_item(REQ_UPDATE,   1'b1, 1'b1, 3'd4, 1'b1, 7'd100, 10'd341));
    send_item(make_item(REQ_FEEDBACK, 1'b1, 1'b1, 3'd2, 1'b0, 7'd42,  10'd1000));
    send_item(make_item(REQ_UPDATE,   1'b0, 1'b0, 3'd3, 1'b0, 7'd80,  10'd17));
    send_item(make_item(REQ_UPDATE,   1'b0, 1'b1, 3'd5, 1'b1, 7'd100, 10'd1023));
    // high start reference against a zero reading: fall, floored
    send_item(make_item(REQ_UPDATE,   1'b1, 1'b0, 3'd3, 1'b1, 7'd1,   10'd1023));
    send_item(make_item(REQ_FEEDBACK, 1'b1, 1'b0, 3'd3, 1'b1, 7'd50,  10'd900));
    send_item(make_item(REQ_UPDATE,   1'b1, 1'b0, 3'd5, 1'b0, 7'd50,  10'd600));
    send_item(make_item(REQ_UPDATE,   1'b0, 1'b0, 3'd5, 1'b0, 7'd50,  10'd600));
    wait_drained();
  endtask

  // --------------------------------------------------------------------------
  // Treatment sessions: a run start, a long active stretch with the sensor
  // drifting up, down or flat, sparse feedback ticks, brief setup entries
  // and level changes, then a stop. Some fully random ticks are mixed in.
  // --------------------------------------------------------------------------
  task automatic run_sessions(input int unsigned n_items);
    int unsigned sent, len, lvl, k;
    logic        hi;
    logic [6:0]  pct;
    int          adc, trend;
    item_t       it;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 15) begin
        it = item_t'($urandom());
        send_item(it);
        sent++;
      end else begin
        len   = $urandom_range(40, 260);
        lvl   = ($urandom_range(9) == 0) ? ($urandom_range(1) ? 0 : 7)
                                         : $urandom_range(1, 6);
        hi    = 1'($urandom_range(1));
        pct   = ($urandom_range(7) == 0) ? 7'($urandom_range(101, 127))
                                         : 7'($urandom_range(0, 100));
        adc   = $urandom_range(0, 1023);
        trend = 0;
        k     = 0;
        while (k < len && sent < n_items) begin
          if ($urandom_range(29) == 0) trend = int'($urandom_range(2)) - 1;
          adc = adc + trend * int'($urandom_range(12)) + int'($urandom_range(4)) - 2;
          if (adc < 0)    adc = 0;
          if (adc > 1023) adc = 1023;
          if ($urandom_range(49) == 0) lvl = $urandom_range(7);
          it = make_item(($urandom_range(23) == 0) ? REQ_FEEDBACK : REQ_UPDATE, 1'b1,
                         ($urandom_range(24) == 0), 3'(lvl), hi, pct, 10'(adc));
          send_item(it);
          sent++;
          k++;
        end
        // wind down with a few stopped ticks
        repeat ($urandom_range(1, 3)) begin
          it = make_item(1'($urandom_range(1)), 1'b0, 1'($urandom_range(1)), 3'(lvl),
                         hi, pct, 10'($urandom_range(1023)));
          send_item(it);
          sent++;
        end
      end
    end
    wait_drained();
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering,
  // so the block fills and stalls its input; the sender then pauses for a
  // full drain before a short burst.
  task automatic test_backpressure_fill();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    recv_hold     = 150;
    repeat (40)
      send_item(make_item(($urandom_range(3) == 0) ? REQ_FEEDBACK : REQ_UPDATE, 1'b1,
                          1'b0, 3'($urandom_range(1, 6)), 1'($urandom_range(1)),
                          7'($urandom_range(100)), 10'($urandom_range(1023))));
    wait_drained();
    repeat (10)
      send_item(item_t'($urandom()));
    wait_drained();
  endtask

  task automatic test_sessions_receiver_busy();
    send_idle_pct = 7;
    recv_idle_pct = 86;
    run_sessions(525);
  endtask

  task automatic test_sessions_sender_sparse();
    send_idle_pct = 86;
    recv_idle_pct = 7;
    run_sessions(525);
  endtask

  task automatic test_sessions_full_rate();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_sessions(525);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_backpressure_fill();
    test_sessions_receiver_busy();
    test_sessions_sender_sparse();
    test_sessions_full_rate();
    if (mismatches == 0)
      $display("heater_feedback_pulse_control_unit: match");
    else
      $display("heater_feedback_pulse_control_unit: mismatch");
    $finish;
  end

endmodule
